/* design/nmea_command_sentence_parser_defines.svh */
// Assertion macros for the command sentence parser checker.
// Used by nmea_cmd_checker; needs clk and rst_n in the scope of each use.
`ifndef NMEA_COMMAND_SENTENCE_PARSER_DEFINES_SVH
`define NMEA_COMMAND_SENTENCE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define NCMD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nmea_cmd assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define NCMD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nmea_cmd assertion failed");

`endif

/* design/nmea_cmd_pkg.sv */
// Shared types, character constants and helper functions for the
// command sentence parser and its checker. No dependencies.
`timescale 1ns / 1ps

package nmea_cmd_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_HEX1    = 3'd3,
        PH_HEX2    = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    // Event codes on event_res
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_VERSION = 3'd1;
    localparam logic [2:0] EV_CALIB   = 3'd2;
    localparam logic [2:0] EV_START   = 3'd3;
    localparam logic [2:0] EV_KILL    = 3'd4;
    localparam logic [2:0] EV_UPDATE  = 3'd5;

    // Stream modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_RAW   = 2'd1;
    localparam logic [1:0] MODE_CAL   = 2'd2;

    // Characters of the sentence format
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_K      = 8'h4B;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LC     = 8'h63;

    // One result item
    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] stream_mode;
        logic       checksum_error;
        logic       go_binary;
    } result_t;

    // Expected header byte at frame positions 1..3 ("PMS")
    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd1:    ch = CH_P;
            3'd2:    ch = CH_M;
            default: ch = CH_S;
        endcase
        return ch;
    endfunction

    // Decode one hex character: {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] res;
        if (ch >= 8'h30 && ch <= 8'h39)
            res = {1'b1, ch[3:0]};
        else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
            res = {1'b1, ch[3:0] + 4'd9};
        else
            res = 5'd0;
        return res;
    endfunction

endpackage

/* design/nmea_command_sentence_parser.sv */
// Command sentence parser top level: framing, checksum and dispatch.
// Depends on nmea_cmd_pkg.
`timescale 1ns / 1ps

// Takes one received character per item and returns exactly one result item for
// each, in order; the result is registered in the output buffer. The parser state
// updates in the accepting cycle, so a new character can be taken every clock
// while in_stall is low. Results go through a two-entry output buffer (output
// register plus skid register): in_stall rises only once both entries hold
// results that the downstream side has not yet taken.
module nmea_command_sentence_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [1:0] stream_mode,
    output logic       checksum_error,
    output logic       go_binary
);
    import nmea_cmd_pkg::*;

    phase_t     phase_reg,  phase_next;
    logic [2:0] pos_reg,    pos_next;
    logic       match_reg,  match_next;
    logic [7:0] csum_reg,   csum_next;
    logic [7:0] cmd_reg,    cmd_next;
    logic [7:0] strm_reg,   strm_next;
    logic [7:0] hex1_reg,   hex1_next;
    logic [1:0] mode_reg,   mode_next;

    logic       out_valid_reg,  out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    result_t    out_data_reg,   out_data_next;
    result_t    skid_data_reg,  skid_data_next;

    result_t    res;
    logic       accept;
    logic       take;
    logic [4:0] hex_hi;
    logic [4:0] hex_lo;

    assign accept = in_valid && !skid_valid_reg;
    assign take   = out_valid_reg && !out_stall;
    assign hex_hi = hex_decode(hex1_reg);
    assign hex_lo = hex_decode(rx_byte);

    // Hold parser state; advance only on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            pos_reg   <= 3'd0;
            match_reg <= 1'b1;
            csum_reg  <= 8'd0;
            cmd_reg   <= 8'd0;
            strm_reg  <= 8'd0;
            hex1_reg  <= 8'd0;
            mode_reg  <= MODE_OFF;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            csum_reg  <= csum_next;
            cmd_reg   <= cmd_next;
            strm_reg  <= strm_next;
            hex1_reg  <= hex1_next;
            mode_reg  <= mode_next;
        end
    end

    // Next parser state and the result of the current character
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        csum_next  = csum_reg;
        cmd_next   = cmd_reg;
        strm_next  = strm_reg;
        hex1_next  = hex1_reg;
        mode_next  = mode_reg;
        res        = '0;

        if (phase_reg == PH_WAIT || phase_reg > PH_DONE)
        begin
            // Hunt for the start token; restart the frame on it
            phase_next = PH_WAIT;
            if (rx_byte == CH_DOLLAR)
            begin
                phase_next = PH_HEADER;
                pos_next   = 3'd0;
                match_next = 1'b1;
                csum_next  = 8'd0;
            end
        end
        else
        begin
            // Advance the saturating frame position and capture letters
            if (pos_reg != 3'd7)
                pos_next = pos_reg + 3'd1;
            if (pos_next == 3'd4)
                cmd_next = rx_byte;
            if (pos_next == 3'd5)
                strm_next = rx_byte;

            case (phase_reg)
                PH_HEADER:
                begin
                    csum_next = csum_reg ^ rx_byte;
                    if (pos_next >= 3'd1 && pos_next <= 3'd3
                        && rx_byte != header_char(pos_next))
                        match_next = 1'b0;
                    if (pos_next >= 3'd3)
                        phase_next = match_next ? PH_PAYLOAD : PH_WAIT;
                end
                PH_PAYLOAD:
                begin
                    if (rx_byte == CH_STAR)
                        phase_next = PH_HEX1;
                    else if (rx_byte == CH_CR || rx_byte == CH_LF)
                        phase_next = PH_DONE;
                    else
                        csum_next = csum_reg ^ rx_byte;
                end
                PH_HEX1:
                begin
                    hex1_next  = rx_byte;
                    phase_next = PH_HEX2;
                end
                PH_HEX2:
                begin
                    // Compare the received checksum with the running XOR
                    if (hex_hi[4] && hex_lo[4] && {hex_hi[3:0], hex_lo[3:0]} == csum_reg)
                        phase_next = PH_DONE;
                    else
                    begin
                        res.checksum_error = 1'b1;
                        phase_next         = PH_WAIT;
                    end
                end
                default:
                begin
                    // Dispatch the command letter on the byte after completion
                    phase_next = PH_WAIT;
                    case (cmd_next)
                        CH_H: res.event_res = EV_VERSION;
                        CH_C: res.event_res = EV_CALIB;
                        CH_S:
                        begin
                            res.event_res = EV_START;
                            if (strm_next == CH_LR)
                                mode_next = MODE_RAW;
                            else if (strm_next == CH_LC)
                                mode_next = MODE_CAL;
                        end
                        CH_K:
                        begin
                            res.event_res = EV_KILL;
                            mode_next     = MODE_OFF;
                        end
                        CH_U:
                        begin
                            res.event_res = EV_UPDATE;
                            mode_next     = MODE_OFF;
                            res.go_binary = 1'b1;
                        end
                        default: res.event_res = EV_NONE;
                    endcase
                end
            endcase
        end
        res.stream_mode = mode_next;
    end

    // Output buffer: fill the output register, spill into skid when it is held
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_data_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    // Hold buffer control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold buffer payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_stall       = skid_valid_reg;
    assign out_valid      = out_valid_reg;
    assign event_res      = out_data_reg.event_res;
    assign stream_mode    = out_data_reg.stream_mode;
    assign checksum_error = out_data_reg.checksum_error;
    assign go_binary      = out_data_reg.go_binary;

endmodule

/* design/nmea_cmd_checker.sv */
// Port-level checker for the command sentence parser, bound to the top level.
// Depends on nmea_cmd_pkg and nmea_command_sentence_parser_defines.svh.
`timescale 1ns / 1ps
`include "nmea_command_sentence_parser_defines.svh"

module nmea_cmd_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] event_res,
    input  logic [1:0] stream_mode,
    input  logic       checksum_error,
    input  logic       go_binary
);
    import nmea_cmd_pkg::*;

    // Binary switch comes only with the update announce event
    `NCMD_ASSERT_IMP(a_gob_update, out_valid && go_binary, event_res == EV_UPDATE)
    // Kill and update announce leave the stream off
    `NCMD_ASSERT_IMP(a_kill_off, out_valid && (event_res == EV_KILL || event_res == EV_UPDATE),
        stream_mode == MODE_OFF)
    // A bad checksum never dispatches
    `NCMD_ASSERT_IMP(a_cerr_noevt, out_valid && checksum_error, event_res == EV_NONE)
    // Result codes stay in range
    `NCMD_ASSERT_IMP(a_range, out_valid, event_res <= EV_UPDATE && stream_mode != 2'd3)
    // A stalled result holds
    `NCMD_ASSERT_NXT(a_hold, out_valid && out_stall,
        out_valid && $stable(event_res) && $stable(stream_mode)
        && $stable(checksum_error) && $stable(go_binary))

endmodule

bind nmea_command_sentence_parser nmea_cmd_checker u_nmea_cmd_checker (.*);
